// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// VTE_ASSERT_IMP checks the consequent in the same cycle.
// VTE_ASSERT_NXT checks it in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define VTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vte: same-cycle check failed");
`define VTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vte: next-cycle check failed");
`else
`define VTE_ASSERT_IMP(lbl, ante, cons)
`define VTE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/vte_pkg.sv =====
package vte_pkg;

  // table and field sizing
  localparam int MAX_NODES  = 128;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int DIST_AW    = 2 * NODE_W;
  localparam int DIST_DEPTH = MAX_NODES * MAX_NODES;
  localparam int TIME_W     = 24;
  localparam int DEMAND_W   = 16;
  localparam int SUM_W      = 32;

  // element queue between front and back (depth must be a power of two)
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_PW + 1;

  // input function codes
  typedef enum logic [1:0] {
    FUNC_NODE = 2'd0,
    FUNC_DIST = 2'd1,
    FUNC_TOUR = 2'd2
  } func_t;

  // configuration register indexes
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]   ready;
    logic [TIME_W-1:0]   due;
    logic [DEMAND_W-1:0] demand;
    logic [TIME_W-1:0]   service;
  } node_attr_t;

  // one classified tour element with its table reads
  typedef struct packed {
    logic [TIME_W-1:0] dist_a;   // previous node (or depot) to this node
    logic [TIME_W-1:0] dist_b;   // this node back to the depot
    node_attr_t        attr;
    logic              depot;
    logic              first;
    logic              last;
  } elem_t;

  typedef struct packed {
    logic [SUM_W-1:0] end_time_total;
    logic [SUM_W-1:0] capacity_excess;
    logic [SUM_W-1:0] lateness_total;
    logic [SUM_W-1:0] violation_total;
  } result_t;

  typedef enum logic [2:0] {
    ST_ARRIVE,
    ST_SERVE,
    ST_RETURN,
    ST_CLOSE,
    ST_EMIT
  } back_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] excess(input logic [SUM_W-1:0] load,
                                              input logic [SUM_W-1:0] cap);
    return (load > cap) ? (load - cap) : '0;
  endfunction

endpackage

// ===== hw/rtl/vte_fifo.sv =====
module vte_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  vte_pkg::elem_t             push_data,
  input  logic                       pop,
  output vte_pkg::elem_t             head,
  output logic [vte_pkg::FIFO_CW-1:0] count
);
  import vte_pkg::*;

  elem_t              entries_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  // pointers wrap naturally at a power-of-two depth
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entries_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

// ===== hw/rtl/vte_front.sv =====
module vte_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_func,
  input  logic [7:0]                  in_node_index,
  input  logic [6:0]                  in_dest_index,
  input  logic [23:0]                 in_ready_time,
  input  logic [23:0]                 in_due_date,
  input  logic [15:0]                 in_demand,
  input  logic [23:0]                 in_service_time,
  input  logic [23:0]                 in_distance,
  input  logic                        in_last,
  input  logic [7:0]                  node_count,
  input  logic [vte_pkg::FIFO_CW-1:0] fifo_cnt,
  output logic                        q_push,
  output vte_pkg::elem_t              q_data
);
  import vte_pkg::*;

  node_attr_t        node_mem [MAX_NODES];
  logic [TIME_W-1:0] dist_mem [DIST_DEPTH];

  logic              accept;
  logic              tour_acc;
  logic              nidx_ok;
  logic              didx_ok;
  logic [NODE_W-1:0] cur;
  logic [DIST_AW-1:0] addr_a;
  logic [DIST_AW-1:0] addr_b;
  node_attr_t        wr_attr;

  logic              started_r, started_nxt;
  logic [NODE_W-1:0] prev_r, prev_nxt;
  logic              s1_valid_r;
  logic              s1_depot_r;
  logic              s1_first_r;
  logic              s1_last_r;
  logic [TIME_W-1:0] dist_a_r;
  logic [TIME_W-1:0] dist_b_r;
  node_attr_t        attr_r;

  // room for the item in flight plus the queue contents
  assign in_full = ({1'b0, fifo_cnt} + (FIFO_CW + 1)'(s1_valid_r))
                   >= (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept   = in_push && !in_full;
  assign tour_acc = accept && (in_func == FUNC_TOUR);

  // index checks and depot alias mapping
  assign nidx_ok = 32'(in_node_index) < MAX_NODES;
  assign didx_ok = 32'(in_dest_index) < MAX_NODES;
  assign cur     = (!nidx_ok || (in_node_index >= node_count)) ? '0
                   : NODE_W'(in_node_index);

  assign addr_a = started_r ? {prev_r, cur} : {NODE_W'(0), cur};
  assign addr_b = {cur, NODE_W'(0)};

  assign wr_attr.ready   = TIME_W'(in_ready_time);
  assign wr_attr.due     = TIME_W'(in_due_date);
  assign wr_attr.demand  = DEMAND_W'(in_demand);
  assign wr_attr.service = TIME_W'(in_service_time);

  // table writes
  always_ff @(posedge clk) begin
    if (accept && (in_func == FUNC_NODE) && nidx_ok) begin
      node_mem[NODE_W'(in_node_index)] <= wr_attr;
    end
    if (accept && (in_func == FUNC_DIST) && nidx_ok && didx_ok) begin
      dist_mem[{NODE_W'(in_node_index), NODE_W'(in_dest_index)}] <= TIME_W'(in_distance);
    end
  end

  // registered table reads for a tour element
  always_ff @(posedge clk) begin
    if (tour_acc) begin
      dist_a_r <= dist_mem[addr_a];
      dist_b_r <= dist_mem[addr_b];
      attr_r   <= node_mem[cur];
    end
  end

  // tour position tracking: previous node and first element
  always_comb begin
    started_nxt = started_r;
    prev_nxt    = prev_r;
    if (tour_acc) begin
      started_nxt = !in_last;
      prev_nxt    = in_last ? '0 : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      prev_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      started_r  <= started_nxt;
      prev_r     <= prev_nxt;
      s1_valid_r <= tour_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tour_acc) begin
      s1_depot_r <= (cur == '0);
      s1_first_r <= !started_r;
      s1_last_r  <= in_last;
    end
  end

  // classified element into the queue
  assign q_push        = s1_valid_r;
  assign q_data.dist_a = dist_a_r;
  assign q_data.dist_b = dist_b_r;
  assign q_data.attr   = attr_r;
  assign q_data.depot  = s1_depot_r;
  assign q_data.first  = s1_first_r;
  assign q_data.last   = s1_last_r;

endmodule

// ===== hw/rtl/vte_back.sv =====
module vte_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  vte_pkg::elem_t            q_head,
  output logic                      q_pop,
  input  logic [vte_pkg::SUM_W-1:0] capacity,
  input  logic                      out_pop,
  output logic                      out_valid,
  output vte_pkg::result_t          result
);
  import vte_pkg::*;

  back_state_t      state_r, state_nxt;
  elem_t            elem_r, elem_nxt;
  logic [SUM_W-1:0] clock_r, clock_nxt;
  logic [SUM_W-1:0] clk_a_r, clk_a_nxt;
  logic [SUM_W-1:0] excess_r, excess_nxt;
  logic [SUM_W-1:0] load_r, load_nxt;
  logic [SUM_W-1:0] end_r, end_nxt;
  logic [SUM_W-1:0] cap_r, cap_nxt;
  logic [SUM_W-1:0] late_r, late_nxt;
  logic [SUM_W-1:0] late_pend_r, late_pend_nxt;
  result_t          out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [SUM_W-1:0] head_ready;
  logic [SUM_W-1:0] head_dist;
  logic [SUM_W-1:0] base_time;
  logic [SUM_W-1:0] wait_time;
  logic [SUM_W-1:0] due32;

  assign head_ready = SUM_W'(q_head.attr.ready);
  assign head_dist  = SUM_W'(q_head.dist_a);
  assign due32      = SUM_W'(elem_r.attr.due);

  // route restart at the depot, then wait for the ready time
  always_comb begin
    base_time = elem_r.depot ? '0 : clk_a_r;
    wait_time = (base_time < SUM_W'(elem_r.attr.ready)) ? SUM_W'(elem_r.attr.ready)
                : base_time;
  end

  always_comb begin
    state_nxt     = state_r;
    elem_nxt      = elem_r;
    clock_nxt     = clock_r;
    clk_a_nxt     = clk_a_r;
    excess_nxt    = excess_r;
    load_nxt      = load_r;
    end_nxt       = end_r;
    cap_nxt       = cap_r;
    late_pend_nxt = '0;
    late_nxt      = sat_add(late_r, late_pend_r);
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;

    // result register transfer
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // travel to the node; excess of the open route for a depot close
      ST_ARRIVE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          elem_nxt   = q_head;
          clk_a_nxt  = q_head.first
                       ? ((head_ready > head_dist) ? head_ready : head_dist)
                       : sat_add(clock_r, head_dist);
          excess_nxt = excess(load_r, capacity);
          state_nxt  = ST_SERVE;
        end
      end
      // depot close, wait, lateness, load and service
      ST_SERVE: begin
        if (elem_r.depot) begin
          end_nxt = sat_add(end_r, clk_a_r);
          cap_nxt = sat_add(cap_r, excess_r);
        end
        late_pend_nxt = (wait_time > due32) ? (wait_time - due32) : '0;
        clock_nxt     = sat_add(wait_time, SUM_W'(elem_r.attr.service));
        load_nxt      = sat_add(elem_r.depot ? '0 : load_r,
                                SUM_W'(elem_r.attr.demand));
        state_nxt     = elem_r.last ? ST_RETURN : ST_ARRIVE;
      end
      // drive back to the depot after the final element
      ST_RETURN: begin
        clock_nxt  = sat_add(clock_r, SUM_W'(elem_r.dist_b));
        excess_nxt = excess(load_r, capacity);
        state_nxt  = ST_CLOSE;
      end
      ST_CLOSE: begin
        end_nxt   = sat_add(end_r, clock_r);
        cap_nxt   = sat_add(cap_r, excess_r);
        state_nxt = ST_EMIT;
      end
      // hand totals to the result register and start a fresh tour
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_nxt.end_time_total  = end_r;
          out_nxt.capacity_excess = cap_r;
          out_nxt.lateness_total  = late_r;
          out_nxt.violation_total = sat_add(cap_r, late_r);
          out_valid_nxt = 1'b1;
          clock_nxt     = '0;
          load_nxt      = '0;
          end_nxt       = '0;
          cap_nxt       = '0;
          late_nxt      = '0;
          state_nxt     = ST_ARRIVE;
        end
      end
      default: begin
        state_nxt = ST_ARRIVE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ARRIVE;
      clock_r     <= '0;
      load_r      <= '0;
      end_r       <= '0;
      cap_r       <= '0;
      late_r      <= '0;
      late_pend_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      load_r      <= load_nxt;
      end_r       <= end_nxt;
      cap_r       <= cap_nxt;
      late_r      <= late_nxt;
      late_pend_r <= late_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    elem_r   <= elem_nxt;
    clk_a_r  <= clk_a_nxt;
    excess_r <= excess_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = out_r;

endmodule

// ===== hw/rtl/vrptw_tour_evaluator_core.sv =====
// Table loads are taken one per cycle while in_full is low; tour elements are taken back to back
// by the front end until the 4-entry queue fills, then scored one at a time by the back end
// (arrive, serve). The last element of a tour adds the return leg, close and result hand-off
// states; its result passes through the front-end register, the queue and these states.
// rst_n is synchronous, active low: clears sums, queue and result; node_count = 1,
// vehicle_capacity = 0. Node and distance tables are not cleared.
`include "assert_macros.svh"

module vrptw_tour_evaluator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_node_index,
  input  logic [6:0]  in_dest_index,
  input  logic [23:0] in_ready_time,
  input  logic [23:0] in_due_date,
  input  logic [15:0] in_demand,
  input  logic [23:0] in_service_time,
  input  logic [23:0] in_distance,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_end_time_total,
  output logic [31:0] out_capacity_excess,
  output logic [31:0] out_lateness_total,
  output logic [31:0] out_violation_total
);
  import vte_pkg::*;

  logic [7:0]         node_count_r;
  logic [SUM_W-1:0]   capacity_r;
  logic               q_push;
  logic               q_pop;
  elem_t              q_data;
  elem_t              q_head;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               out_valid;
  result_t            result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 8'd1;
      capacity_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NODE_COUNT) begin
        node_count_r <= cfg_data[7:0];
      end else begin
        capacity_r <= cfg_data;
      end
    end
  end

  vte_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_node_index   (in_node_index),
    .in_dest_index   (in_dest_index),
    .in_ready_time   (in_ready_time),
    .in_due_date     (in_due_date),
    .in_demand       (in_demand),
    .in_service_time (in_service_time),
    .in_distance     (in_distance),
    .in_last         (in_last),
    .node_count      (node_count_r),
    .fifo_cnt        (fifo_cnt),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  vte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .count     (fifo_cnt)
  );

  vte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (fifo_cnt == '0),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .capacity  (capacity_r),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_empty           = !out_valid;
  assign out_end_time_total  = result.end_time_total;
  assign out_capacity_excess = result.capacity_excess;
  assign out_lateness_total  = result.lateness_total;
  assign out_violation_total = result.violation_total;

  // queue never overflows or underflows; a tour transfer always reaches the queue
  `VTE_ASSERT_IMP(a_fifo_no_overflow, q_push && !q_pop, fifo_cnt != FIFO_CW'(FIFO_DEPTH))
  `VTE_ASSERT_IMP(a_fifo_no_underflow, q_pop, fifo_cnt != '0)
  `VTE_ASSERT_NXT(a_tour_to_queue, in_push && !in_full && (in_func == FUNC_TOUR), q_push)

endmodule

// ===== verif/tb_vrptw_tour_evaluator_core.sv =====
`default_nettype none

module tb_vrptw_tour_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vte_pkg::*;

  // func code the block ignores
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // cycles to let non-result elements drain out of the pipeline
  localparam int SETTLE_CYCLES = 24;
  // nodes whose attributes and distances are all loaded before any tour
  localparam int TAB_NODES = 16;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int SAT_TOUR_LEN = 250;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  node;
    logic [6:0]  dest;
    logic [23:0] ready;
    logic [23:0] due;
    logic [15:0] demand;
    logic [23:0] service;
    logic [23:0] distance;
    logic        last;
  } elem_item_t;

  typedef struct {
    bit [31:0] tot_end;
    bit [31:0] excess;
    bit [31:0] lateness;
    bit [31:0] violation;
  } totals_t;

  // Tracks tables and running tour sums; predicts the totals of each tour
  class tour_cost_tracker;
    bit [23:0] ready_tab [0:MAX_NODES-1];
    bit [23:0] due_tab [0:MAX_NODES-1];
    bit [15:0] demand_tab [0:MAX_NODES-1];
    bit [23:0] service_tab [0:MAX_NODES-1];
    bit [23:0] dist_tab [0:MAX_NODES*MAX_NODES-1];
    int unsigned node_count = 1;
    bit [31:0] capacity = 0;
    bit [31:0] clock_now, load_now, end_sum, excess_sum, late_sum;
    bit [6:0] from_node;
    bit started;
    totals_t expected_totals[$];
    int errors;
    int tours_scored;

    function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit [31:0] over_cap();
      return (load_now > capacity) ? load_now - capacity : 32'd0;
    endfunction

    function void clear_tour();
      clock_now = 0;
      load_now = 0;
      from_node = 0;
      end_sum = 0;
      excess_sum = 0;
      late_sum = 0;
      started = 0;
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    // one accepted input transfer
    function void note_item(elem_item_t it);
      bit [6:0] cur;
      bit [23:0] d0;
      totals_t t;
      if (it.func == FUNC_NODE) begin
        if (it.node < MAX_NODES) begin
          ready_tab[it.node[6:0]] = it.ready;
          due_tab[it.node[6:0]] = it.due;
          demand_tab[it.node[6:0]] = it.demand;
          service_tab[it.node[6:0]] = it.service;
        end
        return;
      end
      if (it.func == FUNC_DIST) begin
        if (it.node < MAX_NODES)
          dist_tab[{it.node[6:0], it.dest}] = it.distance;
        return;
      end
      if (it.func != FUNC_TOUR)
        return;

      // aliases at or above node_count, or beyond the table, are the depot
      cur = (it.node >= node_count || it.node >= MAX_NODES) ? 7'd0 : it.node[6:0];
      if (started) begin
        clock_now = add_sat(clock_now, 32'(dist_tab[{from_node, cur}]));
      end else begin
        d0 = dist_tab[{7'd0, cur}];
        clock_now = (ready_tab[cur] > d0) ? 32'(ready_tab[cur]) : 32'(d0);
        started = 1;
      end

      // depot closes the current route
      if (cur == 0) begin
        excess_sum = add_sat(excess_sum, over_cap());
        load_now = 0;
        end_sum = add_sat(end_sum, clock_now);
        clock_now = 0;
      end
      if (clock_now < 32'(ready_tab[cur]))
        clock_now = 32'(ready_tab[cur]);
      if (clock_now > 32'(due_tab[cur]))
        late_sum = add_sat(late_sum, clock_now - 32'(due_tab[cur]));
      load_now = add_sat(load_now, 32'(demand_tab[cur]));
      clock_now = add_sat(clock_now, 32'(service_tab[cur]));
      from_node = cur;

      if (!it.last)
        return;

      // return leg and final route
      clock_now = add_sat(clock_now, 32'(dist_tab[{cur, 7'd0}]));
      end_sum = add_sat(end_sum, clock_now);
      excess_sum = add_sat(excess_sum, over_cap());
      t.tot_end = end_sum;
      t.excess = excess_sum;
      t.lateness = late_sum;
      t.violation = add_sat(excess_sum, late_sum);
      expected_totals = {expected_totals, t};
      clear_tour();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // one accepted result transfer
    task check_totals(bit [31:0] got_end, bit [31:0] excess, bit [31:0] lateness,
                      bit [31:0] violation);
      totals_t t;
      if (expected_totals.size() == 0) begin
        report($sformatf("result with none expected (end %0d)", got_end));
        return;
      end
      t = expected_totals.pop_front();
      tours_scored++;
      if (got_end !== t.tot_end)
        report($sformatf("end time total exp %0d got %0d", t.tot_end, got_end));
      if (excess !== t.excess)
        report($sformatf("capacity_excess exp %0d got %0d", t.excess, excess));
      if (lateness !== t.lateness)
        report($sformatf("lateness_total exp %0d got %0d", t.lateness, lateness));
      if (violation !== t.violation)
        report($sformatf("violation_total exp %0d got %0d", t.violation, violation));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [7:0]  in_node_index;
  logic [6:0]  in_dest_index;
  logic [23:0] in_ready_time;
  logic [23:0] in_due_date;
  logic [15:0] in_demand;
  logic [23:0] in_service_time;
  logic [23:0] in_distance;
  logic        in_last;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_end_time_total;
  logic [31:0] out_capacity_excess;
  logic [31:0] out_lateness_total;
  logic [31:0] out_violation_total;

  tour_cost_tracker sb;
  bit tx_steady;
  int items_sent;
  int settings_used;

  vrptw_tour_evaluator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_func             (in_func),
    .in_node_index       (in_node_index),
    .in_dest_index       (in_dest_index),
    .in_ready_time       (in_ready_time),
    .in_due_date         (in_due_date),
    .in_demand           (in_demand),
    .in_service_time     (in_service_time),
    .in_distance         (in_distance),
    .in_last             (in_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_end_time_total  (out_end_time_total),
    .out_capacity_excess (out_capacity_excess),
    .out_lateness_total  (out_lateness_total),
    .out_violation_total (out_violation_total)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 65)
      return 0;
    if (r < 96)
      return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_item_t rand_item(logic [1:0] f);
    elem_item_t it;
    it.func = f;
    it.node = 8'($urandom_range(0, 255));
    it.dest = 7'($urandom_range(0, 127));
    it.ready = 24'($urandom);
    it.due = 24'($urandom);
    it.demand = 16'($urandom);
    it.service = 24'($urandom);
    it.distance = 24'($urandom);
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // tour entry: mostly loaded real nodes, some depot, some aliases
  function automatic logic [7:0] pick_node();
    int r;
    int nc;
    int lim;
    r = $urandom_range(0, 99);
    nc = sb.node_count;
    lim = (nc < TAB_NODES) ? nc : TAB_NODES;
    if (r < 12)
      return 8'd0;
    if (r < 24)
      return 8'($urandom_range(255, nc));
    return (lim > 1) ? 8'($urandom_range(1, lim - 1)) : 8'd0;
  endfunction

  // input transfer
  task automatic send(elem_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_func <= it.func;
    in_node_index <= it.node;
    in_dest_index <= it.dest;
    in_ready_time <= it.ready;
    in_due_date <= it.due;
    in_demand <= it.demand;
    in_service_time <= it.service;
    in_distance <= it.distance;
    in_last <= it.last;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_elem(int node, bit last);
    elem_item_t it;
    it = rand_item(FUNC_TOUR);
    it.node = 8'(node);
    it.last = last;
    send(it);
  endtask

  task automatic load_node(int idx, int ready, int due, int demand, int service);
    elem_item_t it;
    it = rand_item(FUNC_NODE);
    it.node = 8'(idx);
    it.ready = 24'(ready);
    it.due = 24'(due);
    it.demand = 16'(demand);
    it.service = 24'(service);
    send(it);
  endtask

  task automatic load_dist(int from, int to, int d);
    elem_item_t it;
    it = rand_item(FUNC_DIST);
    it.node = 8'(from);
    it.dest = 7'(to);
    it.distance = 24'(d);
    send(it);
  endtask

  // random tour, optionally with table loads and ignored items mixed in
  task automatic run_tour(int len, bit noisy);
    elem_item_t it;
    int r;
    for (int k = 0; k < len; k++) begin
      if (noisy && $urandom_range(0, 99) < 8) begin
        r = $urandom_range(0, 2);
        it = rand_item(r == 0 ? FUNC_NODE : (r == 1 ? FUNC_DIST : FUNC_NONE));
        send(it);
      end
      send_elem(pick_node(), k == len - 1);
    end
  endtask

  // hold off until all results are back and the pipeline is empty
  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_NODE_COUNT)
      sb.node_count = 32'(val[7:0]);
    else
      sb.capacity = val;
  endtask

  task automatic set_config(bit [7:0] nc, bit [31:0] cap);
    write_reg(CFG_NODE_COUNT, {24'd0, nc});
    write_reg(CFG_CAPACITY, cap);
    settings_used++;
  endtask

  // result side: pop with random stalls, alternating with steady stretches
  initial begin
    int mode_left;
    int stall_left;
    bit steady;
    mode_left = 0;
    stall_left = 0;
    steady = 0;
    out_pop <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (out_pop && out_empty === 1'b0)
        sb.check_totals(out_end_time_total, out_capacity_excess, out_lateness_total,
                        out_violation_total);
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (steady) begin
        out_pop <= 1'b1;
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 99) < 30)
          stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
                                                     : $urandom_range(20, 60);
      end
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    bit [7:0] nc;
    bit [31:0] cap;
    elem_item_t it;
    sb = new();
    sb.clear_tour();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    in_push <= 1'b0;
    in_func <= FUNC_NODE;
    in_node_index <= '0;
    in_dest_index <= '0;
    in_ready_time <= '0;
    in_due_date <= '0;
    in_demand <= '0;
    in_service_time <= '0;
    in_distance <= '0;
    in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(8'd8, 32'd50);

    // load every node and distance entry a tour can reach
    for (int a = 0; a < TAB_NODES; a++) begin
      it = rand_item(FUNC_NODE);
      it.node = 8'(a);
      send(it);
    end
    for (int a = 0; a < TAB_NODES; a++) begin
      for (int b = 0; b < TAB_NODES; b++) begin
        it = rand_item(FUNC_DIST);
        it.node = 8'(a);
        it.dest = 7'(b);
        send(it);
      end
    end

    // directed: ignored items, field extremes, depot cases
    send(rand_item(FUNC_NONE));
    load_node(200, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
    load_dist(255, 0, 24'hFF_FFFF);
    load_node(0, 0, 24'hFF_FFFF, 0, 0);
    load_node(7, 24'hFF_FFFF, 0, 16'hFFFF, 24'hFF_FFFF);
    load_dist(0, 7, 24'hFF_FFFF);
    load_dist(7, 0, 0);
    load_dist(0, 0, 5);
    load_dist(5, 127, 0);
    // empty first route, then an alias in mid tour
    send_elem(0, 0);
    send_elem(3, 0);
    send_elem(5, 0);
    send_elem(9, 0);
    send_elem(2, 0);
    send_elem(4, 1);
    // single element with extreme attributes
    send_elem(7, 1);
    // alias-only tour
    send_elem(255, 1);
    // repeated depot visits
    send_elem(0, 0);
    send_elem(0, 0);
    send_elem(7, 0);
    send_elem(0, 1);

    // random phases over several register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0: nc = 8'd128;
        1: nc = 8'd1;
        2: nc = 8'd200;
        default: nc = 8'($urandom_range(2, 127));
      endcase
      case (p % 4)
        0: cap = 32'd0;
        1: cap = 32'hFFFF_FFFF;
        2: cap = $urandom_range(0, 300000);
        default: cap = $urandom;
      endcase
      if (p == 5)
        nc = 8'($urandom_range(2, 127));
      set_config(nc, cap);
      tx_steady = (p == 3 || p == 6);
      begin
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
          run_tour(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12), 1'b1);
      end
    end

    // one long tour with maximal service times to drive the sums into saturation
    wait_idle();
    tx_steady = 0;
    set_config(8'd128, 32'd0);
    for (int k = 1; k < TAB_NODES; k++) begin
      it = rand_item(FUNC_NODE);
      it.node = 8'(k);
      it.service = 24'hFF_FFFF;
      send(it);
    end
    for (int k = 0; k < SAT_TOUR_LEN; k++)
      send_elem($urandom_range(1, TAB_NODES - 1), k == SAT_TOUR_LEN - 1);

    wait_idle();
    $display("Sent %0d input transfers; %0d tours scored under %0d register settings,",
             items_sent, sb.tours_scored, settings_used);
    $display("including depot aliases, empty routes, ignored loads and saturated sums.");
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
